// File: rtl/core/symbol_line_extractor_defines.svh
// ---------------------------------------------------------------------------
// Symbol line extractor assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while the synchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SYMBOL_LINE_EXTRACTOR_DEFINES_SVH
`define SYMBOL_LINE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication
`define SLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("symbol line extractor: same-cycle check failed");

// Next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("symbol line extractor: next-cycle check failed");

`endif

// File: rtl/core/sle_pkg.sv
// ---------------------------------------------------------------------------
// Symbol line extractor package
// Transaction types, character codes and register indexes.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CNT_W      = 16;
    localparam int CHARS_W    = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIPE_MODE    = 2'd1;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CHARS_W-1:0] symbol_chars;
        logic [LEN_W-1:0]   symbol_length;
        logic [CNT_W-1:0]   symbol_index;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] symbol_limit;
        logic             pipe_mode;
    } cfg_t;

    // Result handed from the line logic to the result register
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } result_t;

endpackage

// File: rtl/core/sle_in_reg.sv
// ---------------------------------------------------------------------------
// Symbol line extractor input register
// Holds one input transaction until the line logic consumes it.
// ---------------------------------------------------------------------------
module sle_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sle_pkg::in_item_t s_data,
    input  logic              advance,
    output logic              hold_valid,
    output sle_pkg::in_item_t hold_item
);
    import sle_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Free when empty or when the held byte moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

// File: rtl/core/sle_line_fsm.sv
// ---------------------------------------------------------------------------
// Symbol line extractor line logic
// Per-byte line phase, token buffer and per-text symbol count.
// ---------------------------------------------------------------------------
`include "symbol_line_extractor_defines.svh"

module sle_line_fsm #(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sle_pkg::cfg_t     cfg,
    input  logic              advance,
    input  sle_pkg::in_item_t item,
    output sle_pkg::result_t  result
);
    import sle_pkg::*;

    localparam int               BUF_W   = BYTE_W * SYMBOL_BYTES;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(SYMBOL_BYTES);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_TOKEN,
        PH_TRAIL,
        PH_PIPED,
        PH_BAD
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0] count_reg, count_next;

    phase_t           t_phase, cl_phase;
    logic [LEN_W-1:0] t_len, cl_len;
    logic [BUF_W-1:0] t_buf, cl_buf;

    logic [BYTE_W-1:0] c;
    logic              last;
    logic              is_lf;
    logic              is_blank;
    logic              is_sym;
    logic              do_close;
    logic              under_limit;
    logic              emit;

    assign c    = item.text_byte;
    assign last = item.end_of_text;

    assign is_lf    = (c == CH_LF);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    assign is_sym   = ((c >= CH_A) && (c <= CH_Z)) || ((c >= CH_0) && (c <= CH_9)) ||
                      (c == CH_DOT);

    // Line state after taking a non-newline byte
    always_comb begin
        t_phase = phase_reg;
        t_len   = len_reg;
        t_buf   = buf_reg;
        case (phase_reg)
            PH_BAD, PH_PIPED: begin
                t_phase = phase_reg;
            end
            default: begin
                if (is_blank) begin
                    if (phase_reg == PH_TOKEN) begin
                        t_phase = PH_TRAIL;
                    end
                end else if (cfg.pipe_mode && (c == CH_PIPE)) begin
                    t_phase = PH_PIPED;
                end else if (!is_sym || (phase_reg == PH_TRAIL) || (len_reg >= MAX_LEN)) begin
                    // also catches a leading '#' comment
                    t_phase = PH_BAD;
                end else begin
                    for (int i = 0; i < SYMBOL_BYTES; i++) begin
                        if (len_reg == LEN_W'(i)) begin
                            t_buf[i*BYTE_W +: BYTE_W] = c;
                        end
                    end
                    t_len   = len_reg + LEN_W'(1);
                    t_phase = PH_TOKEN;
                end
            end
        endcase
    end

    // A newline closes the line as it stands; otherwise end of text closes it
    // after the byte is taken
    always_comb begin
        do_close = is_lf || last;
        cl_phase = is_lf ? phase_reg : t_phase;
        cl_len   = is_lf ? len_reg   : t_len;
        cl_buf   = is_lf ? buf_reg   : t_buf;

        under_limit = (cfg.symbol_limit == '0) || (count_reg < cfg.symbol_limit);
        emit = do_close && (cl_phase != PH_BAD) && (cl_phase != PH_LEAD) &&
               (cl_len != '0) && under_limit;

        result.emit               = emit;
        result.item.symbol_chars  = CHARS_W'(cl_buf);
        result.item.symbol_length = cl_len;
        result.item.symbol_index  = count_reg;

        if (do_close) begin
            phase_next = PH_LEAD;
            len_next   = '0;
            buf_next   = '0;
        end else begin
            phase_next = t_phase;
            len_next   = t_len;
            buf_next   = t_buf;
        end

        count_next = count_reg;
        if (last) begin
            count_next = '0;
        end else if (emit && (count_reg != CNT_MAX)) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            len_reg   <= '0;
            buf_reg   <= '0;
            count_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            buf_reg   <= buf_next;
            count_reg <= count_next;
        end
    end

    `SLE_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len_reg <= MAX_LEN)
    `SLE_ASSERT_NOW(a_lead_empty, aclk, aresetn, phase_reg == PH_LEAD, len_reg == '0 && buf_reg == '0)
    `SLE_ASSERT_NOW(a_emit_len, aclk, aresetn, advance && emit, cl_len != '0 && cl_len <= MAX_LEN)
    `SLE_ASSERT_NEXT(a_eot_clears, aclk, aresetn, advance && last, count_reg == '0 && phase_reg == PH_LEAD)

endmodule

// File: rtl/core/sle_out_reg.sv
// ---------------------------------------------------------------------------
// Symbol line extractor result register
// Holds one result transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
module sle_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  sle_pkg::result_t   result,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output sle_pkg::out_item_t m_data
);
    import sle_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = result.emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            item_reg <= result.item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = item_reg;

endmodule

// File: rtl/core/symbol_line_extractor.sv
// Path: the newline or end-of-text byte is taken by the input register, passes the
// combinational line logic, and its symbol is then held in the result register.
// Throughput: one byte per cycle while the result register is free.
// The input register takes a byte while a result waits, as long as the line logic moves.
// Reset: synchronous, active low; clears line state, symbol count, valid flags and the
// configuration register (limit zero, pipe mode off). No clearing pass is needed.
// ---------------------------------------------------------------------------
// Symbol line extractor
// Cuts a byte stream into lines and emits each valid trimmed symbol, up to a nonzero limit.
// ---------------------------------------------------------------------------
module symbol_line_extractor #(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sle_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sle_pkg::out_item_t               m_data
);
    import sle_pkg::*;

    cfg_t     cfg_reg;
    logic     hold_valid;
    in_item_t hold_item;
    logic     out_free;
    logic     advance;
    result_t  result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SYMBOL_LIMIT: cfg_reg.symbol_limit <= cfg_wdata;
                REG_PIPE_MODE:    cfg_reg.pipe_mode    <= cfg_wdata[0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The held byte moves on only when the result register can take its outcome
    assign advance = hold_valid && out_free;

    sle_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    sle_line_fsm #(
        .SYMBOL_BYTES (SYMBOL_BYTES)
    ) u_line_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (advance),
        .item    (hold_item),
        .result  (result)
    );

    sle_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
